FILE: design/rsst_pkg.sv
package rsst_pkg;

    localparam int LEAF_COUNT = 1024;
    localparam int VALUE_BITS = 32;
    localparam int IDX_BITS   = 11;
    localparam int SUM_BITS   = 42;
    localparam int NODE_BITS  = $clog2(LEAF_COUNT) + 1;
    localparam int NODE_COUNT = 2 * LEAF_COUNT;
    localparam int LEVELS     = $clog2(LEAF_COUNT);

    // request payload
    typedef struct packed {
        logic                  mode;
        logic [IDX_BITS-1:0]   first_index;
        logic [IDX_BITS-1:0]   last_index;
        logic signed [31:0]    value;
    } t_req;

    // result payload
    typedef struct packed {
        logic signed [SUM_BITS-1:0] range_sum;
        logic signed [31:0]         range_max;
        logic signed [31:0]         range_min;
        logic                       is_rising;
        logic                       is_falling;
        logic                       bad_range;
    } t_rsp;

    // per-node statistics
    typedef struct packed {
        logic signed [SUM_BITS-1:0]   sum;
        logic signed [VALUE_BITS-1:0] mx;
        logic signed [VALUE_BITS-1:0] mn;
        logic                         up;
        logic                         dn;
    } t_stats;

    localparam int STATS_BITS = $bits(t_stats);

    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_WDESC,
        ST_WRD,
        ST_WWAIT,
        ST_WUP,
        ST_QPOP,
        ST_QWAIT,
        ST_QACC,
        ST_OUT
    } t_state;

    function automatic t_stats merge(input t_stats a, input t_stats b);
        t_stats r;
        r.sum = a.sum + b.sum;
        r.mx  = (a.mx > b.mx) ? a.mx : b.mx;
        r.mn  = (a.mn < b.mn) ? a.mn : b.mn;
        r.up  = a.up && b.up && (a.mx <= b.mn);
        r.dn  = a.dn && b.dn && (a.mn >= b.mx);
        return r;
    endfunction

    function automatic t_stats zero_stats();
        t_stats r;
        r = '0;
        r.up = 1'b1;
        r.dn = 1'b1;
        return r;
    endfunction

endpackage

FILE: design/rsst_if.sv
interface rsst_req_if;
    import rsst_pkg::*;
    logic valid;
    logic ready;
    t_req payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface rsst_rsp_if;
    import rsst_pkg::*;
    logic valid;
    logic ready;
    t_rsp payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

FILE: design/range_stats_segment_tree.sv
// Range statistics store: segment tree over LEAF_COUNT signed values.
// Request channel i_req carries mode, first_index, last_index and value.
// A write (mode 0) updates one leaf and every ancestor; it gives no result.
// A query (mode 1) gives one result on o_rsp: sum, max, min, the two
// monotone flags, and bad_range for an empty or out-of-array range.
// One request is worked at a time. A write descends one level a cycle, then
// climbs level by level (write node and read sibling, wait, merge) and is
// done before the next request is taken. A query walks a stack of tree
// nodes, one node a cycle on the walk down, and reads, waits, merges and
// pops each covered node, at most about 2 covered nodes per level; bad
// ranges go straight to the output register. The single node memory sets
// the pace.
// After reset a clearing pass writes zero stats to all 2048 nodes, one a
// cycle; no request is taken during the pass.
// A result waits in the output register until o_rsp.ready; the next request
// is taken once it is delivered.
module range_stats_segment_tree (
    input  logic     i_clk,
    input  logic     i_rst_n,
    rsst_req_if.sink i_req,
    rsst_rsp_if.source o_rsp
);
    import rsst_pkg::*;

    localparam int SP_BITS = $clog2(2 * LEVELS + 2);

    t_state r_state, n_state;
    logic [NODE_BITS-1:0] r_node, n_node;
    t_stats r_cur, n_cur;
    t_stats r_acc, n_acc;
    logic r_have, n_have;
    logic [IDX_BITS-1:0] r_qa, n_qa, r_qb, n_qb;
    t_rsp r_rsp, n_rsp;
    logic r_rvalid, n_rvalid;

    // query stack: node, lo, hi
    logic [NODE_BITS-1:0] r_sk [2*LEVELS+2];
    logic [IDX_BITS-1:0]  r_slo [2*LEVELS+2];
    logic [IDX_BITS-1:0]  r_shi [2*LEVELS+2];
    logic [SP_BITS-1:0]   r_sp, n_sp;
    logic [NODE_BITS-1:0] r_pk;
    logic [IDX_BITS-1:0]  r_plo, r_phi;
    logic push_en;
    logic [NODE_BITS-1:0] push_k;
    logic [IDX_BITS-1:0]  push_lo, push_hi;
    logic [NODE_BITS-1:0] n_pk;
    logic [IDX_BITS-1:0]  n_plo, n_phi;

    logic we;
    logic [NODE_BITS-1:0] waddr, raddr;
    t_stats wdata, rdata;
    logic [STATS_BITS-1:0] rdata_bits;
    logic [IDX_BITS-1:0] mid;
    t_stats leaf_stats;

    rsst_ram #(.DEPTH(NODE_COUNT), .WIDTH(STATS_BITS)) u_ram (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_raddr(raddr),
        .o_rdata(rdata_bits)
    );
    assign rdata = t_stats'(rdata_bits);

    assign i_req.ready   = (r_state == ST_IDLE) && !r_rvalid;
    assign o_rsp.valid   = r_rvalid;
    assign o_rsp.payload = r_rsp;

    assign mid = r_plo + ((r_phi - r_plo) >> 1);

    always_comb begin
        leaf_stats     = '0;
        leaf_stats.sum = {{(SUM_BITS-VALUE_BITS){i_req.payload.value[VALUE_BITS-1]}},
                          i_req.payload.value[VALUE_BITS-1:0]};
        leaf_stats.mx  = i_req.payload.value[VALUE_BITS-1:0];
        leaf_stats.mn  = i_req.payload.value[VALUE_BITS-1:0];
        leaf_stats.up  = 1'b1;
        leaf_stats.dn  = 1'b1;
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_CLEAR;
            r_node   <= '0;
            r_sp     <= '0;
            r_rvalid <= 1'b0;
            r_have   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_node   <= n_node;
            r_sp     <= n_sp;
            r_rvalid <= n_rvalid;
            r_have   <= n_have;
        end
    end

    // payload registers and stack
    always_ff @(posedge i_clk) begin
        r_cur  <= n_cur;
        r_acc  <= n_acc;
        r_qa   <= n_qa;
        r_qb   <= n_qb;
        r_rsp  <= n_rsp;
        r_pk   <= n_pk;
        r_plo  <= n_plo;
        r_phi  <= n_phi;
        if (push_en) begin
            r_sk[r_sp]  <= push_k;
            r_slo[r_sp] <= push_lo;
            r_shi[r_sp] <= push_hi;
        end
    end

    // sequencer
    always_comb begin
        n_state  = r_state;
        n_node   = r_node;
        n_cur    = r_cur;
        n_acc    = r_acc;
        n_have   = r_have;
        n_qa     = r_qa;
        n_qb     = r_qb;
        n_rsp    = r_rsp;
        n_rvalid = r_rvalid;
        n_sp     = r_sp;
        n_pk     = r_pk;
        n_plo    = r_plo;
        n_phi    = r_phi;
        push_en  = 1'b0;
        push_k   = '0;
        push_lo  = '0;
        push_hi  = '0;
        we       = 1'b0;
        waddr    = r_node;
        wdata    = r_cur;
        raddr    = r_node ^ NODE_BITS'(1);

        if (o_rsp.valid && o_rsp.ready) begin
            n_rvalid = 1'b0;
        end

        case (r_state)
            ST_CLEAR: begin
                we    = 1'b1;
                wdata = zero_stats();
                n_node = r_node + 1'b1;
                if (r_node == NODE_BITS'(NODE_COUNT - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_req.valid && i_req.ready) begin
                    n_qa = i_req.payload.first_index;
                    n_qb = i_req.payload.last_index;
                    if (i_req.payload.mode == MODE_WRITE) begin
                        if (i_req.payload.first_index != '0 &&
                            i_req.payload.first_index <= IDX_BITS'(LEAF_COUNT)) begin
                            n_cur   = leaf_stats;
                            n_pk    = NODE_BITS'(1);
                            n_plo   = IDX_BITS'(1);
                            n_phi   = IDX_BITS'(LEAF_COUNT);
                            n_state = ST_WDESC;
                        end
                    end else if (i_req.payload.first_index == '0 ||
                                 i_req.payload.last_index > IDX_BITS'(LEAF_COUNT) ||
                                 i_req.payload.first_index > i_req.payload.last_index) begin
                        n_rsp           = '0;
                        n_rsp.bad_range = 1'b1;
                        n_state         = ST_OUT;
                    end else begin
                        push_en = 1'b1;
                        push_k  = NODE_BITS'(1);
                        push_lo = IDX_BITS'(1);
                        push_hi = IDX_BITS'(LEAF_COUNT);
                        n_sp    = SP_BITS'(1);
                        n_have  = 1'b0;
                        n_state = ST_QPOP;
                    end
                end
            end
            // descend to the leaf, one level a cycle
            ST_WDESC: begin
                if (r_plo == r_phi) begin
                    n_node  = r_pk;
                    n_state = ST_WRD;
                end else if (r_qa <= mid) begin
                    n_pk  = {r_pk[NODE_BITS-2:0], 1'b0};
                    n_phi = mid;
                end else begin
                    n_pk  = {r_pk[NODE_BITS-2:0], 1'b1};
                    n_plo = mid + 1'b1;
                end
            end
            // write the node, read its sibling
            ST_WRD: begin
                we    = 1'b1;
                waddr = r_node;
                wdata = r_cur;
                if (r_node == NODE_BITS'(1)) begin
                    n_state = ST_IDLE;
                end else begin
                    n_state = ST_WWAIT;
                end
            end
            ST_WWAIT: begin
                n_state = ST_WUP;
            end
            ST_WUP: begin
                if (r_node[0]) begin
                    n_cur = merge(rdata, r_cur);
                end else begin
                    n_cur = merge(r_cur, rdata);
                end
                n_node  = r_node >> 1;
                n_state = ST_WRD;
            end
            // query: pop a node, split or read it
            ST_QPOP: begin
                if (r_sp == '0) begin
                    n_rsp            = '0;
                    n_rsp.range_sum  = r_acc.sum;
                    n_rsp.range_max  = r_acc.mx;
                    n_rsp.range_min  = r_acc.mn;
                    n_rsp.is_rising  = r_acc.up;
                    n_rsp.is_falling = r_acc.dn;
                    n_state          = ST_OUT;
                end else begin
                    n_sp  = r_sp - 1'b1;
                    n_pk  = r_sk[r_sp - 1'b1];
                    n_plo = r_slo[r_sp - 1'b1];
                    n_phi = r_shi[r_sp - 1'b1];
                    n_state = ST_QACC;
                    n_node = '0;
                end
            end
            ST_QACC: begin
                if (r_node[0]) begin
                    // read data for the covered node is valid now
                    n_acc   = r_have ? merge(r_acc, rdata) : rdata;
                    n_have  = 1'b1;
                    n_node  = '0;
                    n_state = ST_QPOP;
                end else if (r_qa <= r_plo && r_qb >= r_phi) begin
                    raddr   = r_pk;
                    n_state = ST_QWAIT;
                end else if (r_qb <= mid) begin
                    n_pk  = {r_pk[NODE_BITS-2:0], 1'b0};
                    n_phi = mid;
                end else if (r_qa > mid) begin
                    n_pk  = {r_pk[NODE_BITS-2:0], 1'b1};
                    n_plo = mid + 1'b1;
                end else begin
                    // right half waits on the stack, go left
                    push_en = 1'b1;
                    push_k  = {r_pk[NODE_BITS-2:0], 1'b1};
                    push_lo = mid + 1'b1;
                    push_hi = r_phi;
                    n_sp    = r_sp + 1'b1;
                    n_pk    = {r_pk[NODE_BITS-2:0], 1'b0};
                    n_phi   = mid;
                end
            end
            // keep the covered node on the read port
            ST_QWAIT: begin
                raddr   = r_pk;
                n_node  = NODE_BITS'(1);
                n_state = ST_QACC;
            end
            ST_OUT: begin
                if (!r_rvalid) begin
                    n_rvalid = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

`ifndef NO_ASSERTIONS
    // a held result stays unchanged
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && !o_rsp.ready |=> o_rsp.valid && $stable(o_rsp.payload))
        else $error("result changed while stalled");
    // a bad range carries a zero sum and a clear rising flag
    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && o_rsp.payload.bad_range |->
            o_rsp.payload.range_sum == '0 && !o_rsp.payload.is_rising)
        else $error("bad range with nonzero fields");
    // no request is taken during the clearing pass
    a_clear_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_CLEAR |-> !i_req.ready)
        else $error("request taken during clear");
`endif
endmodule

FILE: design/rsst_ram.sv
module rsst_ram #(
    parameter int DEPTH = 2048,
    parameter int WIDTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // single write port, registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end
endmodule

FILE: bench/range_stats_segment_tree_checker.sv
`timescale 1ns / 100ps

module range_stats_segment_tree_checker (
    input  logic     i_clk,
    input  logic     i_rst_n,
    rsst_req_if.sink i_req,
    rsst_rsp_if.sink i_rsp,
    output int       o_fail_count,
    output int       o_pending
);
    import rsst_pkg::*;

    // flat copy of the stored values, 1-based, index 0 unused
    logic signed [VALUE_BITS-1:0] leaf_val [0:LEAF_COUNT];
    t_rsp stats_queue[$];

    // range statistics folded left to right over the stored values
    function automatic t_rsp range_stats(input int unsigned a, input int unsigned b);
        t_rsp r;
        logic signed [63:0] acc;
        logic signed [VALUE_BITS-1:0] v, prev;
        r = '0;
        if (a < 1 || b > LEAF_COUNT || a > b) begin
            r.bad_range = 1'b1;
            return r;
        end
        acc = 0;
        r.is_rising = 1'b1;
        r.is_falling = 1'b1;
        r.range_max = leaf_val[a];
        r.range_min = leaf_val[a];
        prev = leaf_val[a];
        for (int unsigned i = a; i <= b; i++) begin
            v = leaf_val[i];
            acc += v;
            if (v > r.range_max) r.range_max = v;
            if (v < r.range_min) r.range_min = v;
            if (v < prev) r.is_rising = 1'b0;
            if (v > prev) r.is_falling = 1'b0;
            prev = v;
        end
        r.range_sum = acc[SUM_BITS-1:0];
        return r;
    endfunction

    assign o_pending = stats_queue.size();

    // predict on accepted requests, compare accepted results
    always @(posedge i_clk) begin
        t_rsp exp_r;
        t_rsp got;
        if (!i_rst_n) begin
            for (int i = 0; i <= LEAF_COUNT; i++) leaf_val[i] = '0;
            stats_queue.delete();
            o_fail_count <= 0;
        end else begin
            if (i_req.valid && i_req.ready) begin
                if (i_req.payload.mode == MODE_WRITE) begin
                    if (i_req.payload.first_index >= 1 &&
                        i_req.payload.first_index <= LEAF_COUNT)
                        leaf_val[i_req.payload.first_index] = i_req.payload.value;
                end else begin
                    stats_queue = {stats_queue,
                                   range_stats(32'(i_req.payload.first_index),
                                               32'(i_req.payload.last_index))};
                end
            end
            if (i_rsp.valid && i_rsp.ready) begin
                got = i_rsp.payload;
                if (stats_queue.size() == 0) begin
                    if (o_fail_count < 10)
                        $display("unexpected result %h", got);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    exp_r = stats_queue.pop_front();
                    if (got !== exp_r) begin
                        if (o_fail_count < 10)
                            $display({"result mismatch: sum %0d/%0d max %0d/%0d",
                                      " min %0d/%0d up %b/%b dn %b/%b bad %b/%b"},
                                exp_r.range_sum, got.range_sum,
                                exp_r.range_max, got.range_max,
                                exp_r.range_min, got.range_min,
                                exp_r.is_rising, got.is_rising,
                                exp_r.is_falling, got.is_falling,
                                exp_r.bad_range, got.bad_range);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

FILE: bench/range_stats_segment_tree_tb.sv
`timescale 1ns / 100ps

module range_stats_segment_tree_tb;
    import rsst_pkg::*;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   pending;
    bit   quiet_phase;
    bit   hold_rsp;

    rsst_req_if req_ch ();
    rsst_rsp_if rsp_ch ();

    range_stats_segment_tree u_top (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_ch.sink),
        .o_rsp  (rsp_ch.source)
    );

    range_stats_segment_tree_checker u_chk (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (req_ch.sink),
        .i_rsp       (rsp_ch.sink),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #(12 * 2000000);
        $display("Mismatches found");
        $finish;
    end

    // random value with a bias toward extremes and small numbers
    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 5))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return $urandom_range(0, 8) - 4;
            default: return $urandom;
        endcase
    endfunction

    // index mostly inside the array, sometimes on or past its edges
    function automatic logic [10:0] pick_index();
        case ($urandom_range(0, 9))
            0: return 11'($urandom_range(0, 2047));
            1: return 11'd0;
            2: return IDX_BITS'(LEAF_COUNT);
            default: return 11'($urandom_range(1, LEAF_COUNT));
        endcase
    endfunction

    // send one request, with random gaps before it
    task automatic send_req(input logic mode, input logic [10:0] a,
                            input logic [10:0] b, input logic [31:0] v);
        t_req r;
        int gap;
        if (!quiet_phase && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 5);
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        r.mode = mode;
        r.first_index = a;
        r.last_index = b;
        r.value = v;
        req_ch.valid <= 1'b1;
        req_ch.payload <= r;
        do @(posedge i_clk); while (!req_ch.ready);
    endtask

    // result side ready with random stall bursts, and one long hold-off
    initial begin
        int n;
        bit held;
        held = 1'b0;
        rsp_ch.ready = 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (hold_rsp && !held) begin
                rsp_ch.ready <= 1'b0;
                repeat (400) @(posedge i_clk);
                held = 1'b1;
            end else if (!quiet_phase && $urandom_range(0, 3) == 0) begin
                n = $urandom_range(1, 5);
                rsp_ch.ready <= 1'b0;
                repeat (n) @(posedge i_clk);
            end else begin
                rsp_ch.ready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    // stimulus
    initial begin
        int lo;
        int hi;
        int wait_cnt;
        logic [10:0] p;
        logic [31:0] v;
        quiet_phase = 1'b0;
        hold_rsp = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.payload = '0;
        i_rst_n = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: zero store, bad ranges, extremes, out-of-range writes
        send_req(MODE_QUERY, 11'd1, IDX_BITS'(LEAF_COUNT), 32'd0);
        send_req(MODE_QUERY, 11'd0, 11'd5, 32'd0);
        send_req(MODE_QUERY, 11'd9, 11'd3, 32'd0);
        send_req(MODE_QUERY, 11'd1, 11'd1025, 32'd0);
        send_req(MODE_QUERY, 11'h7ff, 11'h7ff, 32'd0);
        send_req(MODE_WRITE, 11'd0, 11'd0, 32'd77);
        send_req(MODE_WRITE, 11'd1025, 11'd0, 32'd77);
        send_req(MODE_WRITE, 11'h7ff, 11'h7ff, 32'hffffffff);
        send_req(MODE_WRITE, 11'd1, 11'h7ff, 32'h7fffffff);
        send_req(MODE_WRITE, IDX_BITS'(LEAF_COUNT), 11'd0, 32'h80000000);
        send_req(MODE_WRITE, 11'd2, 11'd0, 32'h7fffffff);
        send_req(MODE_WRITE, 11'd3, 11'd0, 32'h7fffffff);
        send_req(MODE_QUERY, 11'd1, 11'd1, 32'hffffffff);
        send_req(MODE_QUERY, IDX_BITS'(LEAF_COUNT), IDX_BITS'(LEAF_COUNT), 32'd0);
        send_req(MODE_QUERY, 11'd1, 11'd3, 32'd0);
        send_req(MODE_QUERY, 11'd1, IDX_BITS'(LEAF_COUNT), 32'd0);
        send_req(MODE_QUERY, 11'd512, 11'd513, 32'd0);

        // fill the array with the largest values for a wide sum
        for (int i = 1; i <= LEAF_COUNT; i++)
            send_req(MODE_WRITE, i[10:0], 11'd0, 32'h7fffffff);
        send_req(MODE_QUERY, 11'd1, IDX_BITS'(LEAF_COUNT), 32'd0);
        for (int i = 1; i <= LEAF_COUNT; i += 3)
            send_req(MODE_WRITE, i[10:0], 11'd0, 32'h80000000);
        send_req(MODE_QUERY, 11'd1, IDX_BITS'(LEAF_COUNT), 32'd0);

        // random: monotone runs, mixed writes and queries
        for (int it = 0; it < 160; it++) begin
            if (it == 40) hold_rsp = 1'b1;
            if (it == 130) quiet_phase = 1'b1;
            case ($urandom_range(0, 4))
                0: begin
                    // short monotone run then a query over it
                    lo = $urandom_range(1, LEAF_COUNT - 8);
                    hi = lo + $urandom_range(1, 7);
                    v = $urandom_range(0, 1000) - 500;
                    for (int k = lo; k <= hi; k++) begin
                        send_req(MODE_WRITE, k[10:0], pick_index(), v);
                        v = v + ($urandom_range(0, 1) ? $urandom_range(0, 3) : 0);
                    end
                    send_req(MODE_QUERY, lo[10:0], hi[10:0], pick_value());
                end
                1, 2: begin
                    p = pick_index();
                    send_req(MODE_WRITE, p, pick_index(), pick_value());
                end
                default: begin
                    lo = $urandom_range(1, LEAF_COUNT);
                    hi = $urandom_range(0, 9) == 0 ? $urandom_range(0, 2047)
                                                   : $urandom_range(lo, LEAF_COUNT);
                    if ($urandom_range(0, 9) == 0) lo = int'(pick_index());
                    send_req(MODE_QUERY, lo[10:0], hi[10:0], pick_value());
                end
            endcase
        end
        req_ch.valid <= 1'b0;

        // drain
        wait_cnt = 0;
        while (pending != 0 && wait_cnt < 200000) begin
            @(posedge i_clk);
            wait_cnt++;
        end
        repeat (100) @(posedge i_clk);
        if (pending == 0 && fail_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
